// ===== rtl/core/iira_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iira_pkg
// Shared constants and types for the indexed insert/remove array.
// ----------------------------------------------------------------------------
package iira_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int POS_BITS  = 4;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_READ      = 2'd0,
    REQ_OVERWRITE = 2'd1,
    REQ_INSERT    = 2'd2,
    REQ_REMOVE    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_e;

  // what every cell does at a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [POS_BITS-1:0]  pos;
    logic [WORD_BITS-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/iira_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iira_cell
// One storage cell of the array; takes a word from a neighbor on a shift.
// ----------------------------------------------------------------------------
module iira_cell
  import iira_pkg::*;
(
  input  logic                 clk_i,
  input  logic [POS_BITS-1:0]  idx_i,
  input  cell_cmd_t            cmd_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] word_o
);

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (cmd_i.op)
      CELL_WRITE: begin
        if (idx_i == cmd_i.pos) word_d = cmd_i.value;
      end
      CELL_SHIFT_UP: begin
        if (idx_i > cmd_i.pos) word_d = left_i;
        else if (idx_i == cmd_i.pos) word_d = cmd_i.value;
      end
      CELL_SHIFT_DOWN: begin
        if (idx_i >= cmd_i.pos) word_d = right_i;
      end
      default: word_d = word_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/indexed_insert_remove_array.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_array
// Ordered word list with read, overwrite, insert and remove by position.
// ----------------------------------------------------------------------------
// result: an accepted item's result is registered in the output register
// throughput: one item per cycle unless output stalls; cells shift together
// reset: count and output valid cleared; cell contents undefined until written
module indexed_insert_remove_array
  import iira_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[3:0], value[35:4], zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_data[31:0], count[36:32], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic [CNT_BITS-1:0]  count_q, count_d;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] out_data_q, out_data_d;
  status_e              out_status_q, out_status_d;
  logic [CNT_BITS-1:0]  out_count_q;

  logic [WORD_BITS-1:0] words [DEPTH];
  cell_cmd_t            cmd;

  req_type_e            req;
  logic [POS_BITS-1:0]  pos;
  logic [WORD_BITS-1:0] value;
  logic                 accept;
  logic                 pos_in_range;
  logic                 pos_le_count;

  assign req   = req_type_e'(s_axis_tuser);
  assign pos   = s_axis_tdata[POS_BITS-1:0];
  assign value = s_axis_tdata[POS_BITS+WORD_BITS-1:POS_BITS];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_in_range = CNT_BITS'(pos) < count_q;
  assign pos_le_count = CNT_BITS'(pos) <= count_q;

  always_comb begin
    cmd.op       = CELL_HOLD;
    cmd.pos      = pos;
    cmd.value    = value;
    count_d      = count_q;
    out_data_d   = '0;
    out_status_d = ST_OK;
    case (req)
      REQ_READ: begin
        if (pos_in_range) out_data_d = words[pos];
        else out_status_d = ST_BAD_POS;
      end
      REQ_OVERWRITE: begin
        if (pos_in_range) cmd.op = CELL_WRITE;
        else out_status_d = ST_BAD_POS;
      end
      REQ_INSERT: begin
        // full is checked before the position
        if (count_q == CNT_BITS'(DEPTH)) begin
          out_status_d = ST_FULL;
        end else if (!pos_le_count) begin
          out_status_d = ST_BAD_POS;
        end else begin
          cmd.op  = CELL_SHIFT_UP;
          count_d = count_q + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos_in_range) begin
          cmd.op  = CELL_SHIFT_DOWN;
          count_d = count_q - 1'b1;
        end else begin
          out_status_d = ST_BAD_POS;
        end
      end
      default: out_status_d = ST_BAD_POS;
    endcase
    if (!accept) begin
      cmd.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end
    iira_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (POS_BITS'(g)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_data_q};
  assign m_axis_tuser  = out_status_q;

endmodule
